>>> rtl/uhid_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// uhid_pkg
// Shared types and constants for the HID control endpoint handler.
// ---------------------------------------------------------------------------
package uhid_pkg;

	// endpoint zero packet size and number of string descriptors served
	localparam int unsigned EP0_PACKET_BYTES = 32;
	localparam int unsigned STRING_COUNT     = 4;

	// event codes (beat kind)
	localparam logic [2:0] CMD_SETUP      = 3'd0;
	localparam logic [2:0] CMD_FRAME_TICK = 3'd1;
	localparam logic [2:0] CMD_BUS_RESET  = 3'd2;
	localparam logic [2:0] CMD_IN_ACK     = 3'd3;
	localparam logic [2:0] CMD_OUT_DATA   = 3'd4;
	localparam logic [2:0] CMD_IDLE_CHECK = 3'd5;

	// bmRequestType fields
	localparam logic [7:0] RT_KIND_MASK  = 8'h60;
	localparam logic [7:0] RT_RCPT_MASK  = 8'h1f;
	localparam logic [7:0] KIND_STANDARD = 8'h00;
	localparam logic [7:0] KIND_CLASS    = 8'h20;
	localparam logic [7:0] RCPT_DEVICE   = 8'h00;
	localparam logic [7:0] RCPT_IFACE    = 8'h01;
	localparam logic [7:0] RCPT_ENDPOINT = 8'h02;

	// standard requests
	localparam logic [7:0] REQ_GET_STATUS     = 8'h00;
	localparam logic [7:0] REQ_SET_ADDRESS    = 8'h05;
	localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'h06;
	localparam logic [7:0] REQ_GET_CONFIG     = 8'h08;
	localparam logic [7:0] REQ_SET_CONFIG     = 8'h09;

	// HID class requests
	localparam logic [7:0] HID_GET_REPORT = 8'h01;
	localparam logic [7:0] HID_GET_IDLE   = 8'h02;
	localparam logic [7:0] HID_SET_REPORT = 8'h09;
	localparam logic [7:0] HID_SET_IDLE   = 8'h0a;

	// descriptor types in wValue high byte
	localparam logic [7:0] DT_DEVICE = 8'h01;
	localparam logic [7:0] DT_CONFIG = 8'h02;
	localparam logic [7:0] DT_STRING = 8'h03;
	localparam logic [7:0] DT_REPORT = 8'h22;

	// endpoint addresses
	localparam logic [7:0] EP_IN_ADDR  = 8'h81;
	localparam logic [7:0] EP_OUT_ADDR = 8'h01;

	// descriptor ids towards the ROM
	localparam logic [2:0] DID_NONE    = 3'd0;
	localparam logic [2:0] DID_DEVICE  = 3'd1;
	localparam logic [2:0] DID_CONFIG  = 3'd2;
	localparam logic [2:0] DID_STRING0 = 3'd3;
	localparam logic [2:0] DID_REPORT  = 3'd7;

	// device states
	localparam logic [1:0] ST_DEFAULT    = 2'd0;
	localparam logic [1:0] ST_ADDRESSED  = 2'd1;
	localparam logic [1:0] ST_CONFIGURED = 2'd2;

	// report forward codes
	localparam logic [1:0] FWD_NONE       = 2'd0;
	localparam logic [1:0] FWD_GET_REPORT = 2'd1;
	localparam logic [1:0] FWD_SET_DATA   = 2'd2;

	// configuration register indexes
	localparam logic [2:0] CFG_DEVICE_LEN = 3'd0;
	localparam logic [2:0] CFG_CONFIG_LEN = 3'd1;
	localparam logic [2:0] CFG_STRING0    = 3'd2;
	localparam logic [2:0] CFG_STRING1    = 3'd3;
	localparam logic [2:0] CFG_STRING2    = 3'd4;
	localparam logic [2:0] CFG_STRING3    = 3'd5;
	localparam logic [2:0] CFG_REPORT_LEN = 3'd6;

	// one result beat
	typedef struct packed {
		logic       stall_res;
		logic       status_ack;
		logic       arm_in;
		logic [6:0] in_count;
		logic       payload_source;
		logic [7:0] payload_byte0;
		logic [7:0] payload_byte1;
		logic [2:0] descriptor_id;
		logic [7:0] descriptor_offset;
		logic [1:0] report_forward;
		logic       idle_elapsed;
		logic [1:0] device_state_out;
	} result_t;

	// one input beat
	typedef struct packed {
		logic [2:0] command;
		logic [7:0] request_type;
		logic [7:0] request_code;
		logic [7:0] value_low;
		logic [7:0] value_high;
		logic [7:0] index_low;
		logic [7:0] length_low;
		logic [7:0] length_high;
		logic       in_endpoint_halted;
		logic       out_endpoint_halted;
	} event_t;

endpackage

>>> rtl/usb_hid_control_request_handler.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// usb_hid_control_request_handler
// Endpoint zero request decoder for a HID device: device state, idle rate,
// frame counter and descriptor packetizer, one result beat per event beat.
// ---------------------------------------------------------------------------
// Pipeline: input register, then result register with the decode between them.
// Throughput: one event per cycle unless m_tready stalls the result register;
// state updates as the event enters it, so back-to-back events see fresh state.
// Reset: arst_n clears device state, counters and packetizer and loads the
// descriptor length registers with their defaults; both stages come up empty.
module usb_hid_control_request_handler (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_wdata,
	// event input
	input  logic        s_tvalid,
	output logic        s_tready,
	// [7:0] request_type [15:8] request_code [23:16] value_low [31:24] value_high
	// [39:32] index_low [47:40] length_low [55:48] length_high
	// [56] in_endpoint_halted [57] out_endpoint_halted, rest zero
	input  logic [63:0] s_tdata,
	// [2:0] command
	input  logic [2:0]  s_tuser,
	// result output
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] stall_res [1] status_ack [2] arm_in [9:3] in_count
	// [17:10] payload_byte0 [25:18] payload_byte1 [28:26] descriptor_id
	// [36:29] descriptor_offset [38:37] report_forward [39] idle_elapsed
	// [41:40] device_state_out, rest zero
	output logic [47:0] m_tdata,
	// [0] payload_source
	output logic [0:0]  m_tuser
);

	localparam logic [7:0] PKT_BYTES = 8'(uhid_pkg::EP0_PACKET_BYTES);
	localparam logic [2:0] STR_COUNT = 3'(uhid_pkg::STRING_COUNT);

	// configuration registers
	logic [7:0] dev_len_q, cfg_len_q, rpt_len_q;
	logic [7:0] str_len_q [4];

	// device state
	logic [1:0]  dev_state_q;
	logic        active_cfg_q;
	logic [7:0]  idle_rate_q;
	logic [15:0] frame_count_q;
	logic [7:0]  bytes_left_q;
	logic [2:0]  cur_desc_q;
	logic [7:0]  next_off_q;
	logic [7:0]  last_code_q;

	// pipeline
	logic                  valid_s1;
	uhid_pkg::event_t      ev_s1;
	logic                  out_valid_q;
	uhid_pkg::result_t     res_q;
	logic                  advance;

	// next-state and result
	uhid_pkg::result_t res_d;
	logic [1:0]  dev_state_d;
	logic        active_cfg_d;
	logic [7:0]  idle_rate_d;
	logic [15:0] frame_count_d;
	logic [7:0]  bytes_left_d;
	logic [2:0]  cur_desc_d;
	logic [7:0]  next_off_d;
	logic [7:0]  last_code_d;

	// descriptor lookup and packetizer
	logic [2:0] lk_id;
	logic [7:0] lk_len;
	logic [7:0] want;
	logic [7:0] lk_left;
	logic       pk_new;
	logic [7:0] pk_left, pk_off, pk_n;
	logic [2:0] pk_id;
	logic [7:0] kind, rcpt;
	logic       idle_due;
	logic       ep_bit;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_len_q    <= 8'd18;
			cfg_len_q    <= 8'd34;
			str_len_q[0] <= 8'd4;
			str_len_q[1] <= 8'd2;
			str_len_q[2] <= 8'd2;
			str_len_q[3] <= 8'd2;
			rpt_len_q    <= 8'd0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				uhid_pkg::CFG_DEVICE_LEN: dev_len_q    <= cfg_wdata;
				uhid_pkg::CFG_CONFIG_LEN: cfg_len_q    <= cfg_wdata;
				uhid_pkg::CFG_STRING0:    str_len_q[0] <= cfg_wdata;
				uhid_pkg::CFG_STRING1:    str_len_q[1] <= cfg_wdata;
				uhid_pkg::CFG_STRING2:    str_len_q[2] <= cfg_wdata;
				uhid_pkg::CFG_STRING3:    str_len_q[3] <= cfg_wdata;
				uhid_pkg::CFG_REPORT_LEN: rpt_len_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ev_s1.command             <= s_tuser;
			ev_s1.request_type        <= s_tdata[7:0];
			ev_s1.request_code        <= s_tdata[15:8];
			ev_s1.value_low           <= s_tdata[23:16];
			ev_s1.value_high          <= s_tdata[31:24];
			ev_s1.index_low           <= s_tdata[39:32];
			ev_s1.length_low          <= s_tdata[47:40];
			ev_s1.length_high         <= s_tdata[55:48];
			ev_s1.in_endpoint_halted  <= s_tdata[56];
			ev_s1.out_endpoint_halted <= s_tdata[57];
		end
	end

	// descriptor lookup from the setup packet
	always_comb begin
		lk_id  = uhid_pkg::DID_NONE;
		lk_len = 8'd0;
		case (ev_s1.value_high)
			uhid_pkg::DT_DEVICE: begin
				lk_id  = uhid_pkg::DID_DEVICE;
				lk_len = dev_len_q;
			end
			uhid_pkg::DT_CONFIG: begin
				lk_id  = uhid_pkg::DID_CONFIG;
				lk_len = cfg_len_q;
			end
			uhid_pkg::DT_STRING: begin
				if ({5'd0, STR_COUNT} > ev_s1.value_low) begin
					lk_id  = uhid_pkg::DID_STRING0 + {1'b0, ev_s1.value_low[1:0]};
					lk_len = str_len_q[ev_s1.value_low[1:0]];
				end
			end
			uhid_pkg::DT_REPORT: begin
				if (ev_s1.index_low == 8'd0) begin
					lk_id  = uhid_pkg::DID_REPORT;
					lk_len = rpt_len_q;
				end
			end
			default: ;
		endcase
	end

	// requested size clipped to 255, then to the descriptor length
	assign want    = (ev_s1.length_high != 8'd0) ? 8'hff : ev_s1.length_low;
	assign lk_left = (want < lk_len) ? want : lk_len;

	// packetizer source: a fresh descriptor on setup, else the running one
	assign pk_new  = (ev_s1.command == uhid_pkg::CMD_SETUP);
	assign pk_left = pk_new ? lk_left : bytes_left_q;
	assign pk_off  = pk_new ? 8'd0 : next_off_q;
	assign pk_id   = pk_new ? lk_id : cur_desc_q;
	assign pk_n    = (pk_left < PKT_BYTES) ? pk_left : PKT_BYTES;

	assign kind     = ev_s1.request_type & uhid_pkg::RT_KIND_MASK;
	assign rcpt     = ev_s1.request_type & uhid_pkg::RT_RCPT_MASK;
	assign idle_due = (idle_rate_q != 8'd0) &&
		(frame_count_q >= {6'd0, idle_rate_q, 2'b00});
	assign ep_bit   = (ev_s1.index_low == uhid_pkg::EP_IN_ADDR)  ? ev_s1.in_endpoint_halted :
		(ev_s1.index_low == uhid_pkg::EP_OUT_ADDR) ? ev_s1.out_endpoint_halted : 1'b0;

	// event decode
	always_comb begin
		logic do_pkt;
		do_pkt        = 1'b0;
		res_d         = '0;
		dev_state_d   = dev_state_q;
		active_cfg_d  = active_cfg_q;
		idle_rate_d   = idle_rate_q;
		frame_count_d = frame_count_q;
		bytes_left_d  = bytes_left_q;
		cur_desc_d    = cur_desc_q;
		next_off_d    = next_off_q;
		last_code_d   = last_code_q;

		case (ev_s1.command)
			uhid_pkg::CMD_SETUP: begin
				last_code_d  = ev_s1.request_code;
				bytes_left_d = 8'd0;
				cur_desc_d   = uhid_pkg::DID_NONE;
				next_off_d   = 8'd0;
				if (kind == uhid_pkg::KIND_STANDARD) begin
					if (rcpt == uhid_pkg::RCPT_DEVICE) begin
						case (ev_s1.request_code)
							uhid_pkg::REQ_GET_STATUS: begin
								if (dev_state_q != uhid_pkg::ST_DEFAULT &&
										dev_state_q != 2'd3 && ev_s1.index_low == 8'd0) begin
									res_d.arm_in   = 1'b1;
									res_d.in_count = 7'd2;
								end else begin
									res_d.stall_res = 1'b1;
								end
							end
							uhid_pkg::REQ_SET_ADDRESS: dev_state_d = uhid_pkg::ST_ADDRESSED;
							uhid_pkg::REQ_GET_DESCRIPTOR: begin
								if (lk_id == uhid_pkg::DID_NONE) res_d.stall_res = 1'b1;
								else do_pkt = 1'b1;
							end
							uhid_pkg::REQ_GET_CONFIG: begin
								if (dev_state_q == uhid_pkg::ST_ADDRESSED) begin
									res_d.arm_in   = 1'b1;
									res_d.in_count = 7'd1;
								end else if (dev_state_q == uhid_pkg::ST_CONFIGURED) begin
									res_d.arm_in        = 1'b1;
									res_d.in_count      = 7'd1;
									res_d.payload_byte0 = {7'd0, active_cfg_q};
								end else begin
									res_d.stall_res = 1'b1;
								end
							end
							uhid_pkg::REQ_SET_CONFIG: begin
								if (ev_s1.value_low == 8'd0) begin
									dev_state_d      = uhid_pkg::ST_ADDRESSED;
									active_cfg_d     = 1'b0;
									res_d.status_ack = 1'b1;
								end else if (ev_s1.value_low == 8'd1) begin
									dev_state_d      = uhid_pkg::ST_CONFIGURED;
									active_cfg_d     = 1'b1;
									res_d.status_ack = 1'b1;
								end else begin
									res_d.stall_res = 1'b1;
								end
							end
							default: ;
						endcase
					end else if (rcpt == uhid_pkg::RCPT_IFACE) begin
						if (ev_s1.request_code == uhid_pkg::REQ_GET_STATUS) begin
							if (dev_state_q == uhid_pkg::ST_CONFIGURED) begin
								res_d.arm_in   = 1'b1;
								res_d.in_count = 7'd2;
							end
						end else if (ev_s1.request_code == uhid_pkg::REQ_GET_DESCRIPTOR) begin
							if (lk_id == uhid_pkg::DID_NONE) res_d.stall_res = 1'b1;
							else do_pkt = 1'b1;
						end else begin
							res_d.stall_res = 1'b1;
						end
					end else if (rcpt == uhid_pkg::RCPT_ENDPOINT) begin
						if (ev_s1.request_code == uhid_pkg::REQ_GET_STATUS) begin
							if (dev_state_q == uhid_pkg::ST_CONFIGURED) begin
								res_d.arm_in        = 1'b1;
								res_d.in_count      = 7'd2;
								res_d.payload_byte0 = {7'd0, ep_bit};
							end
						end else begin
							res_d.stall_res = 1'b1;
						end
					end else begin
						res_d.stall_res = 1'b1;
					end
				end else if (kind == uhid_pkg::KIND_CLASS) begin
					case (ev_s1.request_code)
						uhid_pkg::HID_SET_REPORT: ;  // data arrives in the OUT stage
						uhid_pkg::HID_GET_REPORT: res_d.report_forward = uhid_pkg::FWD_GET_REPORT;
						uhid_pkg::HID_GET_IDLE: begin
							res_d.arm_in        = 1'b1;
							res_d.in_count      = 7'd1;
							res_d.payload_byte0 = idle_rate_q;
						end
						uhid_pkg::HID_SET_IDLE: begin
							idle_rate_d      = ev_s1.value_high;
							frame_count_d    = 16'd0;
							res_d.arm_in     = 1'b1;
							res_d.status_ack = 1'b1;
						end
						default: res_d.stall_res = 1'b1;
					endcase
				end else begin
					res_d.stall_res = 1'b1;
				end
			end
			uhid_pkg::CMD_FRAME_TICK: frame_count_d = frame_count_q + 16'd1;
			uhid_pkg::CMD_BUS_RESET: begin
				dev_state_d  = uhid_pkg::ST_DEFAULT;
				active_cfg_d = 1'b0;
			end
			uhid_pkg::CMD_IN_ACK: do_pkt = 1'b1;
			uhid_pkg::CMD_OUT_DATA: begin
				if (last_code_q == uhid_pkg::HID_SET_REPORT)
					res_d.report_forward = uhid_pkg::FWD_SET_DATA;
				res_d.arm_in     = 1'b1;
				res_d.status_ack = 1'b1;
			end
			uhid_pkg::CMD_IDLE_CHECK: begin
				if (idle_due) begin
					res_d.idle_elapsed = 1'b1;
					frame_count_d      = 16'd0;
				end
			end
			default: ;
		endcase

		// send one packet of the descriptor, or a zero-length status packet
		if (do_pkt) begin
			cur_desc_d   = pk_id;
			res_d.arm_in = 1'b1;
			if (pk_left == 8'd0) begin
				res_d.status_ack = 1'b1;
				next_off_d       = pk_off;
				bytes_left_d     = 8'd0;
			end else begin
				res_d.in_count          = pk_n[6:0];
				res_d.payload_source    = 1'b1;
				res_d.descriptor_id     = pk_id;
				res_d.descriptor_offset = pk_off;
				next_off_d              = pk_off + pk_n;
				bytes_left_d            = pk_left - pk_n;
			end
		end

		res_d.device_state_out = dev_state_d;
	end

	// state registers, updated as the beat moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_state_q   <= uhid_pkg::ST_DEFAULT;
			active_cfg_q  <= 1'b0;
			idle_rate_q   <= 8'd0;
			frame_count_q <= 16'd0;
			bytes_left_q  <= 8'd0;
			cur_desc_q    <= uhid_pkg::DID_NONE;
			next_off_q    <= 8'd0;
			last_code_q   <= 8'd0;
		end else if (advance) begin
			dev_state_q   <= dev_state_d;
			active_cfg_q  <= active_cfg_d;
			idle_rate_q   <= idle_rate_d;
			frame_count_q <= frame_count_d;
			bytes_left_q  <= bytes_left_d;
			cur_desc_q    <= cur_desc_d;
			next_off_q    <= next_off_d;
			last_code_q   <= last_code_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = res_q.payload_source;
	assign m_tdata  = {6'd0, res_q.device_state_out, res_q.idle_elapsed,
		res_q.report_forward, res_q.descriptor_offset, res_q.descriptor_id,
		res_q.payload_byte1, res_q.payload_byte0, res_q.in_count,
		res_q.arm_in, res_q.status_ack, res_q.stall_res};

`ifndef SYNTH
	// a stall never comes with a packet or a status acknowledge
	a_stall_alone: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_q.stall_res |-> !res_q.arm_in && !res_q.status_ack)
		else $error("stall beat also arms or acknowledges");

	// a ROM packet carries a real descriptor and a non-empty size within one packet
	a_rom_packet: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_q.payload_source |-> res_q.arm_in && res_q.in_count != 7'd0 &&
		{1'b0, res_q.in_count} <= PKT_BYTES && res_q.descriptor_id != uhid_pkg::DID_NONE)
		else $error("malformed descriptor packet");

	// device state never takes the unused code
	a_state_code: assert property (@(posedge clk) disable iff (!arst_n)
		dev_state_q != 2'd3)
		else $error("device state out of range");

	// an IN ack with bytes pending moves the offset on by the packet size
	a_offset_step: assert property (@(posedge clk) disable iff (!arst_n)
		advance && ev_s1.command == uhid_pkg::CMD_IN_ACK && bytes_left_q != 8'd0 |=>
		next_off_q == $past(next_off_q) + {1'b0, res_q.in_count})
		else $error("packetizer offset slip");
`endif

endmodule
